FILE: rtl/bounded_message_fifo_macros.svh
// Assertion macros for the bounded message FIFO.
`ifndef BOUNDED_MESSAGE_FIFO_MACROS_SVH
`define BOUNDED_MESSAGE_FIFO_MACROS_SVH
`ifndef SYNTHESIS
`define BMF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BMF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BMF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BMF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/bmf_pkg.sv
// Shared types and constants of the bounded message FIFO.
`default_nettype none
package bmf_pkg;
	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 5;
	localparam int LEN_W      = 7;
	localparam int CODE_W     = 2;
	localparam int ACT_W      = 3;
	localparam int SLOT_W_MAX = 8;

	localparam logic [ACT_W-1:0] ACT_ENQ    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DEQ    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DROP   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_STATUS = 3'd4;

	localparam logic [CODE_W-1:0] CODE_OK       = 2'd0;
	localparam logic [CODE_W-1:0] CODE_FULL     = 2'd1;
	localparam logic [CODE_W-1:0] CODE_OVERLONG = 2'd2;
	localparam logic [CODE_W-1:0] CODE_EMPTY    = 2'd3;

	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_PEEK  = 2'd1;
	localparam logic [1:0] KIND_DEQ   = 2'd2;
	localparam logic [1:0] KIND_DROP  = 2'd3;

	localparam logic REG_MAX_MSGS  = 1'b0;
	localparam logic REG_MAX_BYTES = 1'b1;

	// work handed from front to back
	typedef struct packed {
		logic [1:0]            kind;
		logic [CODE_W-1:0]     code;
		logic [CNT_W-1:0]      count;
		logic [LEN_W-1:0]      head_len;
		logic [LEN_W-1:0]      len;
		logic [SLOT_W_MAX-1:0] slot;
		logic [SLOT_W_MAX-1:0] next_slot;
	} cmd_t;

	// back tells front that a head operation is finished
	typedef struct packed {
		logic             valid;
		logic [LEN_W-1:0] head_len;
	} done_t;
endpackage
`default_nettype wire

FILE: rtl/bounded_message_fifo.sv
// Bounded message FIFO top level: config registers, front, queue, back, stores.
// Enqueue bytes are taken one per cycle when not busy; a last byte's result is registered
// in the command queue, then in the output register. Status, empty and refused results
// take the same path. Peek or dequeue of an n-byte head: n results, one per cycle, after the
// queue and the length and run states; busy until done. Drop of a held head gives one result.
// Receiver cannot stall. Reset clears control state, sets limits to 16 messages, 64 bytes.
`default_nettype none
`include "bounded_message_fifo_macros.svh"
module bounded_message_fifo
	import bmf_pkg::*;
#(
	parameter int MSG_SLOTS  = 16,
	parameter int SLOT_BYTES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output      logic [31:0]       prdata,
	output      logic              pready,
	input  wire logic              start,
	output      logic              busy,
	input  wire logic [ACT_W-1:0]  action,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              in_last,
	output      logic              out_strobe,
	output      logic [BYTE_W-1:0] out_byte,
	output      logic              out_last,
	output      logic [CODE_W-1:0] result_code,
	output      logic [CNT_W-1:0]  message_count,
	output      logic [LEN_W-1:0]  head_length
);
	localparam int SW         = $clog2(MSG_SLOTS);
	localparam int OW         = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
	localparam int BYTE_DEPTH = MSG_SLOTS * (2 ** OW);
	localparam int Q_DEPTH    = 2;

	logic [CNT_W-1:0]  max_messages_q;
	logic [LEN_W-1:0]  max_bytes_q;
	logic              cfg_wr;

	logic              q_full;
	logic              q_empty;
	logic              push;
	logic              pop;
	cmd_t              push_cmd;
	cmd_t              q_head;
	done_t             done;

	logic              bwe;
	logic [SW+OW-1:0]  bwaddr;
	logic [BYTE_W-1:0] bwdata;
	logic              bre;
	logic [SW+OW-1:0]  braddr;
	logic [BYTE_W-1:0] brdata;
	logic              lwe;
	logic [SW-1:0]     lwaddr;
	logic [LEN_W-1:0]  lwdata;
	logic              lre;
	logic [SW-1:0]     lraddr;
	logic [LEN_W-1:0]  lrdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_messages_q <= CNT_W'(16);
			max_bytes_q    <= LEN_W'(64);
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MAX_MSGS:  max_messages_q <= pwdata[CNT_W-1:0];
				REG_MAX_BYTES: max_bytes_q    <= pwdata[LEN_W-1:0];
				default:       max_bytes_q    <= max_bytes_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_MSGS:  prdata = 32'(max_messages_q);
			REG_MAX_BYTES: prdata = 32'(max_bytes_q);
			default:       prdata = '0;
		endcase
	end

	bmf_front #(
		.MSG_SLOTS (MSG_SLOTS),
		.SLOT_BYTES(SLOT_BYTES)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.action           (action),
		.in_byte          (in_byte),
		.in_last          (in_last),
		.max_messages     (max_messages_q),
		.max_message_bytes(max_bytes_q),
		.q_full           (q_full),
		.done             (done),
		.busy             (busy),
		.push             (push),
		.push_cmd         (push_cmd),
		.bwe              (bwe),
		.bwaddr           (bwaddr),
		.bwdata           (bwdata),
		.lwe              (lwe),
		.lwaddr           (lwaddr),
		.lwdata           (lwdata)
	);

	bmf_queue #(
		.DEPTH(Q_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.head    (q_head)
	);

	bmf_back #(
		.MSG_SLOTS (MSG_SLOTS),
		.SLOT_BYTES(SLOT_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.pop          (pop),
		.bre          (bre),
		.braddr       (braddr),
		.brdata       (brdata),
		.lre          (lre),
		.lraddr       (lraddr),
		.lrdata       (lrdata),
		.done         (done),
		.out_strobe   (out_strobe),
		.out_byte     (out_byte),
		.out_last     (out_last),
		.result_code  (result_code),
		.message_count(message_count),
		.head_length  (head_length)
	);

	bmf_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BYTE_DEPTH)
	) u_byte_ram (
		.clk  (clk),
		.we   (bwe),
		.waddr(bwaddr),
		.wdata(bwdata),
		.re   (bre),
		.raddr(braddr),
		.rdata(brdata)
	);

	bmf_ram #(
		.WIDTH(LEN_W),
		.DEPTH(MSG_SLOTS)
	) u_len_ram (
		.clk  (clk),
		.we   (lwe),
		.waddr(lwaddr),
		.wdata(lwdata),
		.re   (lre),
		.raddr(lraddr),
		.rdata(lrdata)
	);

	`BMF_ASSERT_NXT(a_stream_gapless, clk, arst_n, out_strobe && !out_last, out_strobe, "result stream broke before its last transfer")
	`BMF_ASSERT_IMP(a_no_queue_overflow, clk, arst_n, push, !q_full, "command pushed into a full queue")
	`BMF_ASSERT_IMP(a_empty_no_head, clk, arst_n, out_strobe && message_count == '0, head_length == '0, "head length reported on an empty queue")
	`BMF_ASSERT_NXT(a_ready_after_done, clk, arst_n, done.valid, !busy, "front still busy after head operation finished")
endmodule
`default_nettype wire

FILE: rtl/bmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

FILE: rtl/bmf_queue.sv
// Short command queue between the front and back of the message FIFO.
`default_nettype none
module bmf_queue
	import bmf_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output      logic full,
	output      logic empty,
	output      cmd_t head
);
	localparam int PW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	cmd_t            entry_q [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [LW-1:0]   level_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (level_q == LW'(DEPTH));
	assign empty   = (level_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/bmf_front.sv
// Front end: takes commands, stores message bytes, keeps queue bookkeeping.
`default_nettype none
module bmf_front
	import bmf_pkg::*;
#(
	parameter int MSG_SLOTS  = 16,
	parameter int SLOT_BYTES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [ACT_W-1:0]  action,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              in_last,
	input  wire logic [CNT_W-1:0]  max_messages,
	input  wire logic [LEN_W-1:0]  max_message_bytes,
	input  wire logic              q_full,
	input  wire done_t             done,
	output      logic              busy,
	output      logic              push,
	output      cmd_t              push_cmd,
	output      logic              bwe,
	output      logic [$clog2(MSG_SLOTS)+((SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1)-1:0] bwaddr,
	output      logic [BYTE_W-1:0] bwdata,
	output      logic              lwe,
	output      logic [$clog2(MSG_SLOTS)-1:0] lwaddr,
	output      logic [LEN_W-1:0]  lwdata
);
	localparam int SW = $clog2(MSG_SLOTS);
	localparam int OW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;

	logic [SW-1:0]     head_q;
	logic [SW-1:0]     tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [LEN_W-1:0]  head_len_q;
	logic [LEN_W-1:0]  wlen_q;
	logic [CODE_W-1:0] refusal_q;
	logic              wait_q;

	logic              accept;
	logic              at_limit;
	logic [LEN_W:0]    wlen_inc;
	logic              too_long;
	logic [CODE_W-1:0] refusal_a;
	logic [CODE_W-1:0] refusal_b;
	logic [CODE_W-1:0] end_code;
	logic [LEN_W-1:0]  wlen_next;
	logic [SW-1:0]     head_next;
	logic [SW-1:0]     tail_next;
	logic              enq_ok;
	logic              head_op;

	assign busy   = wait_q || q_full;
	assign accept = start && !busy;

	assign at_limit  = (count_q >= max_messages) || (int'(count_q) >= MSG_SLOTS);
	assign wlen_inc  = {1'b0, wlen_q} + (LEN_W + 1)'(1);
	assign too_long  = (wlen_inc > {1'b0, max_message_bytes}) || (int'(wlen_inc) > SLOT_BYTES);
	// full is judged when the first byte arrives and again at the last byte
	assign refusal_a = (wlen_q == '0 && refusal_q == CODE_OK && at_limit) ? CODE_FULL
		: refusal_q;
	assign refusal_b = (refusal_a == CODE_OK && too_long) ? CODE_OVERLONG : refusal_a;
	assign end_code  = (refusal_b == CODE_OK && at_limit) ? CODE_FULL : refusal_b;
	assign wlen_next = (wlen_q == {LEN_W{1'b1}}) ? wlen_q : wlen_inc[LEN_W-1:0];
	assign head_next = (head_q == SW'(MSG_SLOTS - 1)) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == SW'(MSG_SLOTS - 1)) ? '0 : tail_q + 1'b1;
	assign enq_ok    = (end_code == CODE_OK);
	assign head_op   = (action == ACT_PEEK || action == ACT_DEQ || action == ACT_DROP)
		&& count_q != '0;

	assign bwe    = accept && action == ACT_ENQ && refusal_b == CODE_OK;
	assign bwaddr = {tail_q, wlen_q[OW-1:0]};
	assign bwdata = in_byte;
	assign lwe    = accept && action == ACT_ENQ && in_last && enq_ok;
	assign lwaddr = tail_q;
	assign lwdata = wlen_next;

	always_comb begin
		push     = 1'b0;
		push_cmd = '0;
		case (action)
			ACT_ENQ: begin
				push          = in_last;
				push_cmd.kind = KIND_PLAIN;
				push_cmd.code = end_code;
				if (enq_ok) begin
					push_cmd.count    = count_q + 1'b1;
					push_cmd.head_len = (count_q == '0) ? wlen_next : head_len_q;
				end else begin
					push_cmd.count    = count_q;
					push_cmd.head_len = (count_q == '0) ? '0 : head_len_q;
				end
			end
			ACT_PEEK, ACT_DEQ, ACT_DROP: begin
				push = 1'b1;
				if (count_q == '0) begin
					push_cmd.kind = KIND_PLAIN;
					push_cmd.code = CODE_EMPTY;
				end else begin
					case (action)
						ACT_PEEK: push_cmd.kind = KIND_PEEK;
						ACT_DEQ:  push_cmd.kind = KIND_DEQ;
						default:  push_cmd.kind = KIND_DROP;
					endcase
					push_cmd.code      = CODE_OK;
					push_cmd.count     = (action == ACT_PEEK) ? count_q : count_q - 1'b1;
					push_cmd.head_len  = head_len_q;
					push_cmd.len       = head_len_q;
					push_cmd.slot      = SLOT_W_MAX'(head_q);
					push_cmd.next_slot = SLOT_W_MAX'(head_next);
				end
			end
			ACT_STATUS: begin
				push              = 1'b1;
				push_cmd.kind     = KIND_PLAIN;
				push_cmd.code     = CODE_OK;
				push_cmd.count    = count_q;
				push_cmd.head_len = (count_q == '0) ? '0 : head_len_q;
			end
			default: begin
				push = 1'b0;
			end
		endcase
		push = push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			head_len_q <= '0;
			wlen_q     <= '0;
			refusal_q  <= CODE_OK;
			wait_q     <= 1'b0;
		end else begin
			if (done.valid) begin
				wait_q     <= 1'b0;
				head_len_q <= done.head_len;
			end
			if (accept) begin
				if (action == ACT_ENQ) begin
					if (in_last) begin
						wlen_q    <= '0;
						refusal_q <= CODE_OK;
						if (enq_ok) begin
							tail_q  <= tail_next;
							count_q <= count_q + 1'b1;
							if (count_q == '0) begin
								head_len_q <= wlen_next;
							end
						end
					end else begin
						wlen_q    <= wlen_next;
						refusal_q <= refusal_b;
					end
				end else if (head_op) begin
					// back reports the new head length when it is done
					wait_q <= 1'b1;
					if (action != ACT_PEEK) begin
						head_q  <= head_next;
						count_q <= count_q - 1'b1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/bmf_back.sv
// Back end: turns queued commands into results, streams head bytes out.
`default_nettype none
module bmf_back
	import bmf_pkg::*;
#(
	parameter int MSG_SLOTS  = 16,
	parameter int SLOT_BYTES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire cmd_t              q_head,
	output      logic              pop,
	output      logic              bre,
	output      logic [$clog2(MSG_SLOTS)+((SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1)-1:0] braddr,
	input  wire logic [BYTE_W-1:0] brdata,
	output      logic              lre,
	output      logic [$clog2(MSG_SLOTS)-1:0] lraddr,
	input  wire logic [LEN_W-1:0]  lrdata,
	output      done_t             done,
	output      logic              out_strobe,
	output      logic [BYTE_W-1:0] out_byte,
	output      logic              out_last,
	output      logic [CODE_W-1:0] result_code,
	output      logic [CNT_W-1:0]  message_count,
	output      logic [LEN_W-1:0]  head_length
);
	localparam int SW = $clog2(MSG_SLOTS);
	localparam int OW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_LEN  = 2'd1;
	localparam logic [1:0] B_RUN  = 2'd2;

	logic [1:0]        state_q;
	cmd_t              cur_q;
	logic [LEN_W-1:0]  idx_q;

	logic              strobe_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic [CODE_W-1:0] code_q;
	logic [CNT_W-1:0]  count_q;
	logic [LEN_W-1:0]  hlen_q;

	logic [LEN_W-1:0]  nidx;
	logic              final_run;
	logic [LEN_W-1:0]  run_hlen;
	logic              emit;
	logic [BYTE_W-1:0] emit_byte;
	logic              emit_last;
	logic [CODE_W-1:0] emit_code;
	logic [CNT_W-1:0]  emit_count;
	logic [LEN_W-1:0]  emit_hlen;

	assign nidx      = idx_q + 1'b1;
	assign final_run = (cur_q.kind == KIND_DROP) || ({1'b0, nidx} == {1'b0, cur_q.len});
	assign run_hlen  = (cur_q.kind == KIND_PEEK) ? cur_q.head_len
		: ((cur_q.count == '0) ? '0 : lrdata);

	assign pop    = (state_q == B_IDLE) && !q_empty;
	assign bre    = (state_q == B_LEN) || (state_q == B_RUN);
	assign braddr = {cur_q.slot[SW-1:0], (state_q == B_RUN) ? nidx[OW-1:0] : OW'(0)};
	assign lre    = (state_q == B_LEN);
	assign lraddr = cur_q.next_slot[SW-1:0];

	assign done.valid    = (state_q == B_RUN) && final_run;
	assign done.head_len = run_hlen;

	always_comb begin
		emit       = 1'b0;
		emit_byte  = '0;
		emit_last  = 1'b1;
		emit_code  = CODE_OK;
		emit_count = cur_q.count;
		emit_hlen  = run_hlen;
		case (state_q)
			B_IDLE: begin
				emit       = !q_empty && q_head.kind == KIND_PLAIN;
				emit_code  = q_head.code;
				emit_count = q_head.count;
				emit_hlen  = q_head.head_len;
			end
			B_RUN: begin
				emit      = 1'b1;
				emit_byte = (cur_q.kind == KIND_DROP) ? '0 : brdata;
				emit_last = final_run;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
		if (emit) begin
			byte_q  <= emit_byte;
			last_q  <= emit_last;
			code_q  <= emit_code;
			count_q <= emit_count;
			hlen_q  <= emit_hlen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			case (state_q)
				B_IDLE: begin
					if (pop && q_head.kind != KIND_PLAIN) begin
						state_q <= B_LEN;
					end
				end
				B_LEN: begin
					// length of the next head and byte 0 are read here
					idx_q   <= '0;
					state_q <= B_RUN;
				end
				B_RUN: begin
					idx_q <= nidx;
					if (final_run) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign out_strobe    = strobe_q;
	assign out_byte      = byte_q;
	assign out_last      = last_q;
	assign result_code   = code_q;
	assign message_count = count_q;
	assign head_length   = hlen_q;
endmodule
`default_nettype wire

FILE: bench/tb.sv
// Testbench for the bounded message FIFO: directed table, then random message traffic.
`default_nettype none
module tb;
	import bmf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS          = 16;
	localparam int BYTES_PER_SLOT = 64;
	localparam int SETTLE_CYCLES  = 8;
	localparam int CYCLE_LIMIT    = 500000;
	localparam int PLAN_ROWS      = 36;

	// actions the block ignores
	localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic [CODE_W-1:0] code;
		logic [CNT_W-1:0]  count;
		logic [LEN_W-1:0]  hlen;
	} fifo_result_t;

	typedef struct packed {
		bit                is_reg;
		logic              reg_sel;
		logic [LEN_W-1:0]  reg_value;
		logic [ACT_W-1:0]  act;
		logic [BYTE_W-1:0] data;
		logic              last;
		bit                typed;
		logic [CODE_W-1:0] code;
		logic [CNT_W-1:0]  count;
		logic [LEN_W-1:0]  hlen;
	} plan_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              start;
	logic              busy;
	logic [ACT_W-1:0]  action;
	logic [BYTE_W-1:0] in_byte;
	logic              in_last;
	logic              out_strobe;
	logic [BYTE_W-1:0] out_byte;
	logic              out_last;
	logic [CODE_W-1:0] result_code;
	logic [CNT_W-1:0]  message_count;
	logic [LEN_W-1:0]  head_length;

	bounded_message_fifo #(.MSG_SLOTS(SLOTS), .SLOT_BYTES(BYTES_PER_SLOT)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.action(action), .in_byte(in_byte), .in_last(in_last),
		.out_strobe(out_strobe), .out_byte(out_byte), .out_last(out_last),
		.result_code(result_code), .message_count(message_count),
		.head_length(head_length)
	);

	// mirror of the queue
	logic [BYTE_W-1:0] mirror_bytes [0:SLOTS-1][0:BYTES_PER_SLOT-1];
	logic [LEN_W-1:0]  mirror_len [0:SLOTS-1];
	logic [3:0]        head_ptr;
	logic [3:0]        tail_ptr;
	logic [CNT_W-1:0]  held;
	logic [LEN_W-1:0]  wr_len;
	logic [CODE_W-1:0] wr_refusal;
	logic [CNT_W-1:0]  lim_msgs;
	logic [LEN_W-1:0]  lim_bytes;

	fifo_result_t outcome[$];
	fifo_result_t expected_results[$];
	fifo_result_t oldest;

	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned items_sent;
	int unsigned results_checked;
	int unsigned quiet_waits;
	int unsigned sender_slack;
	bit          start_high;

	plan_row_t plan [0:PLAN_ROWS-1] = '{
		'{0, 0, 7'd0,  ACT_STATUS, 8'h00, 0, 1, CODE_OK,       5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_PEEK,   8'h00, 0, 1, CODE_EMPTY,    5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_DEQ,    8'h00, 0, 1, CODE_EMPTY,    5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_DROP,   8'h00, 0, 1, CODE_EMPTY,    5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_SPARE_FIRST, 8'h5A, 1, 0, CODE_OK,  5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_SPARE_LAST,  8'hA5, 0, 0, CODE_OK,  5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_ENQ,    8'h00, 1, 1, CODE_OK,       5'd1, 7'd1},
		'{0, 0, 7'd0,  ACT_ENQ,    8'hFF, 0, 0, CODE_OK,       5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_ENQ,    8'hA5, 1, 1, CODE_OK,       5'd2, 7'd1},
		'{0, 0, 7'd0,  ACT_PEEK,   8'h00, 0, 0, CODE_OK,       5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_DEQ,    8'h00, 0, 0, CODE_OK,       5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_STATUS, 8'h00, 0, 1, CODE_OK,       5'd1, 7'd2},
		'{0, 0, 7'd0,  ACT_DEQ,    8'h00, 0, 0, CODE_OK,       5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_DROP,   8'h00, 0, 1, CODE_EMPTY,    5'd0, 7'd0},
		'{1, REG_MAX_MSGS,  7'd1,  ACT_ENQ, 8'h00, 0, 0, CODE_OK, 5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_ENQ,    8'h11, 1, 1, CODE_OK,       5'd1, 7'd1},
		'{0, 0, 7'd0,  ACT_ENQ,    8'h22, 1, 1, CODE_FULL,     5'd1, 7'd1},
		'{1, REG_MAX_BYTES, 7'd1,  ACT_ENQ, 8'h00, 0, 0, CODE_OK, 5'd0, 7'd0},
		// full and overlong at once: full wins
		'{0, 0, 7'd0,  ACT_ENQ,    8'h33, 0, 0, CODE_OK,       5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_ENQ,    8'h44, 1, 1, CODE_FULL,     5'd1, 7'd1},
		'{0, 0, 7'd0,  ACT_DROP,   8'h00, 0, 1, CODE_OK,       5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_ENQ,    8'h55, 0, 0, CODE_OK,       5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_ENQ,    8'h66, 1, 1, CODE_OVERLONG, 5'd0, 7'd0},
		'{1, REG_MAX_MSGS,  7'd0,  ACT_ENQ, 8'h00, 0, 0, CODE_OK, 5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_ENQ,    8'h77, 1, 1, CODE_FULL,     5'd0, 7'd0},
		'{1, REG_MAX_MSGS,  7'd16, ACT_ENQ, 8'h00, 0, 0, CODE_OK, 5'd0, 7'd0},
		'{1, REG_MAX_BYTES, 7'd0,  ACT_ENQ, 8'h00, 0, 0, CODE_OK, 5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_ENQ,    8'h88, 1, 1, CODE_OVERLONG, 5'd0, 7'd0},
		'{1, REG_MAX_BYTES, 7'd64, ACT_ENQ, 8'h00, 0, 0, CODE_OK, 5'd0, 7'd0},
		// count limit drops to zero between first and last byte
		'{0, 0, 7'd0,  ACT_ENQ,    8'h99, 0, 0, CODE_OK,       5'd0, 7'd0},
		'{1, REG_MAX_MSGS,  7'd0,  ACT_ENQ, 8'h00, 0, 0, CODE_OK, 5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_ENQ,    8'h9A, 1, 1, CODE_FULL,     5'd0, 7'd0},
		'{1, REG_MAX_MSGS,  7'd16, ACT_ENQ, 8'h00, 0, 0, CODE_OK, 5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_ENQ,    8'h12, 0, 0, CODE_OK,       5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_ENQ,    8'h34, 1, 0, CODE_OK,       5'd0, 7'd0},
		'{0, 0, 7'd0,  ACT_PEEK,   8'h00, 0, 0, CODE_OK,       5'd0, 7'd0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int count_cap();
		return (lim_msgs < SLOTS) ? lim_msgs : SLOTS;
	endfunction

	function automatic int byte_cap();
		return (lim_bytes < BYTES_PER_SLOT) ? lim_bytes : BYTES_PER_SLOT;
	endfunction

	task automatic stage(input logic [BYTE_W-1:0] data, input logic last_flag,
			input logic [CODE_W-1:0] code);
		fifo_result_t r;
		r.data  = data;
		r.last  = last_flag;
		r.code  = code;
		r.count = held;
		r.hlen  = (held != 0) ? mirror_len[head_ptr] : '0;
		outcome.push_back(r);
	endtask

	// works out the results of one accepted transfer and updates the mirror
	task automatic predict(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] data,
			input logic last_flag);
		logic [3:0]        slot;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] verdict;
		outcome.delete();
		case (act)
			ACT_ENQ: begin
				if (wr_len == 0 && wr_refusal == CODE_OK && held >= count_cap())
					wr_refusal = CODE_FULL;
				if (wr_refusal == CODE_OK && wr_len + 1 > byte_cap())
					wr_refusal = CODE_OVERLONG;
				if (wr_refusal == CODE_OK && wr_len < BYTES_PER_SLOT)
					mirror_bytes[tail_ptr][wr_len] = data;
				if (wr_len < 127)
					wr_len++;
				if (last_flag) begin
					verdict = wr_refusal;
					if (verdict == CODE_OK && held >= count_cap())
						verdict = CODE_FULL;
					if (verdict == CODE_OK) begin
						mirror_len[tail_ptr] = wr_len;
						tail_ptr++;
						held++;
					end
					wr_len = '0;
					wr_refusal = CODE_OK;
					stage('0, 1'b1, verdict);
				end
			end
			ACT_PEEK, ACT_DEQ: begin
				if (held == 0) begin
					stage('0, 1'b1, CODE_EMPTY);
				end else begin
					slot = head_ptr;
					len = mirror_len[slot];
					if (act == ACT_DEQ) begin
						head_ptr++;
						held--;
					end
					for (int i = 0; i < len; i++)
						stage(mirror_bytes[slot][i], i + 1 == len, CODE_OK);
				end
			end
			ACT_DROP: begin
				if (held == 0) begin
					stage('0, 1'b1, CODE_EMPTY);
				end else begin
					head_ptr++;
					held--;
					stage('0, 1'b1, CODE_OK);
				end
			end
			ACT_STATUS: stage('0, 1'b1, CODE_OK);
			default: ;
		endcase
	endtask

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic transfer(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] data,
			input logic last_flag, input bit typed, input fifo_result_t want);
		start <= 1'b1;
		start_high = 1'b1;
		action <= act;
		in_byte <= data;
		in_last <= last_flag;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict(act, data, last_flag);
		if (typed)
			expected_results.push_back(want);
		else
			foreach (outcome[i])
				expected_results.push_back(outcome[i]);
		if (act <= ACT_STATUS)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic pause(input int unsigned cycles);
		if (cycles != 0) begin
			start <= 1'b0;
			start_high = 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	// hold off until every expected result is in and the block has gone quiet
	task automatic settle();
		if (start_high) begin
			start <= 1'b0;
			start_high = 1'b0;
		end
		while (expected_results.size() != 0 || busy)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		quiet_waits++;
	endtask

	task automatic write_reg(input logic sel, input logic [LEN_W-1:0] value);
		logic [LEN_W-1:0] readback;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= {25'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (sel == REG_MAX_MSGS)
			lim_msgs = value[CNT_W-1:0];
		else
			lim_bytes = value;
		readback = (sel == REG_MAX_MSGS) ? {2'b00, value[CNT_W-1:0]} : value;
		@(negedge clk);
		if (prdata != {25'd0, readback}) begin
			$error("prdata: expected %0d, got %0d", readback, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			pause($urandom_range(0, sender_slack));
			transfer(ACT_ENQ, BYTE_W'($urandom_range(0, 255)), i + 1 == len, 0, '0);
		end
	endtask

	task automatic random_phase(input logic [CNT_W-1:0] msgs, input logic [LEN_W-1:0] bytes,
			input int unsigned quota, input bit long_first);
		int unsigned stop_at;
		int unsigned pick;
		logic [ACT_W-1:0] head_op;
		settle();
		write_reg(REG_MAX_MSGS, {2'b00, msgs});
		write_reg(REG_MAX_BYTES, bytes);
		sender_slack = 9;
		if (long_first) begin
			// past the length limit far enough to saturate the byte count, then a full slot
			send_message(130);
			send_message(BYTES_PER_SLOT);
			transfer(ACT_DROP, '0, 1'b0, 0, '0);
			transfer(ACT_PEEK, '0, 1'b0, 0, '0);
			transfer(ACT_DEQ, '0, 1'b0, 0, '0);
		end
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 19) == 0)
				sender_slack = ($urandom_range(0, 2) == 0) ? 0 : 9;
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				pause($urandom_range(0, sender_slack));
				transfer(ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)),
					BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, '0);
			end else if (pick < 5) begin
				settle();
			end else if (pick < ((held < count_cap()) ? 60 : 30)) begin
				send_message(($urandom_range(0, 11) == 0) ? $urandom_range(1, 70)
					: $urandom_range(1, 5));
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2:    head_op = ACT_PEEK;
					3, 4, 5, 6: head_op = ACT_DEQ;
					7, 8:       head_op = ACT_DROP;
					default:    head_op = ACT_STATUS;
				endcase
				pause($urandom_range(0, sender_slack));
				// payload fields are don't-care here but still toggle
				transfer(head_op, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					0, '0);
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_strobe) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: out_byte %0d result_code %0d",
					out_byte, result_code);
				mismatches++;
			end else begin
				oldest = expected_results.pop_front();
				check_field("out_byte", oldest.data, out_byte);
				check_field("out_last", oldest.last, out_last);
				check_field("result_code", oldest.code, result_code);
				check_field("message_count", oldest.count, message_count);
				check_field("head_length", oldest.hlen, head_length);
				results_checked++;
			end
		end
	end

	initial begin
		fifo_result_t want;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		action = ACT_STATUS;
		in_byte = '0;
		in_last = 1'b0;
		start_high = 1'b0;
		cycle_count = 0;
		mismatches = 0;
		items_sent = 0;
		results_checked = 0;
		quiet_waits = 0;
		sender_slack = 9;
		head_ptr = '0;
		tail_ptr = '0;
		held = '0;
		wr_len = '0;
		wr_refusal = CODE_OK;
		lim_msgs = 5'd16;
		lim_bytes = 7'd64;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				settle();
				write_reg(plan[i].reg_sel, plan[i].reg_value);
			end else begin
				want.data  = '0;
				want.last  = 1'b1;
				want.code  = plan[i].code;
				want.count = plan[i].count;
				want.hlen  = plan[i].hlen;
				pause($urandom_range(0, 9));
				transfer(plan[i].act, plan[i].data, plan[i].last, plan[i].typed, want);
			end
		end

		random_phase(5'd16, 7'd64, 20, 1);
		random_phase(5'd1, 7'd1, 30, 0);
		random_phase(5'd31, 7'd127, 30, 0);
		random_phase(5'd4, 7'd8, 30, 0);
		random_phase(5'd2, 7'd64, 30, 0);
		random_phase(5'd16, 7'd3, 30, 0);
		random_phase(CNT_W'($urandom_range(1, 16)), LEN_W'($urandom_range(1, 64)), 30, 0);
		settle();

		$display("Run covered %0d transfers in and %0d results checked over %0d quiet waits.",
			items_sent, results_checked, quiet_waits);
		$display("Limits went from zero to full width; messages ran from 1 to 130 bytes.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/bmf_pkg.sv
rtl/bmf_ram.sv
rtl/bmf_queue.sv
rtl/bmf_front.sv
rtl/bmf_back.sv
rtl/bounded_message_fifo.sv
bench/tb.sv
